// File: rtl/core/mfb_pkg.sv
// ----------------------------------------------------------------------------
// mfb_pkg
// Shared constants, state and command codes for the max flow block.
// ----------------------------------------------------------------------------
package mfb_pkg;

   localparam int MAX_NODES_DEF = 16;
   localparam int CAP_BITS_DEF  = 16;

   localparam int NODE_W  = 4;
   localparam int CAPIN_W = 16;
   localparam int FLOW_W  = 20;
   localparam int NCNT_W  = 5;

   localparam logic [FLOW_W-1:0] FLOW_MAX    = 20'hFFFFF;
   localparam logic [NCNT_W-1:0] NCOUNT_RST  = 5'd16;
   localparam logic              REQ_WRITE   = 1'b0;
   localparam logic              REQ_RUN     = 1'b1;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_COPY_RD,
      ST_COPY_WR,
      ST_BFS_INIT,
      ST_POP,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_AUG_INIT,
      ST_MIN_RD,
      ST_MIN_CHK,
      ST_UPD_INIT,
      ST_UPD_RD_F,
      ST_UPD_WR_F,
      ST_UPD_WR_R,
      ST_DONE
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_CLEAR,
      OP_WRITE,
      OP_START,
      OP_COPY_RD,
      OP_COPY_WR,
      OP_BFS_INIT,
      OP_POP,
      OP_SCAN_RD,
      OP_SCAN_CHK,
      OP_AUG_INIT,
      OP_MIN_RD,
      OP_MIN_CHK,
      OP_UPD_INIT,
      OP_UPD_RD_F,
      OP_UPD_WR_F,
      OP_UPD_WR_R,
      OP_FINISH
   } op_type;

   typedef struct packed {
      logic run_err;
      logic rsp_busy;
      logic q_empty;
      logic hit;
      logic v_snk;
      logic v_last;
      logic u_src;
      logic cnt_last;
   } status_type;

endpackage

// File: rtl/core/mfb_ram.sv
// ----------------------------------------------------------------------------
// mfb_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mfb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/mfb_ctrl.sv
// ----------------------------------------------------------------------------
// mfb_ctrl
// Sequencer: clear sweep, copy, breadth-first search, bottleneck walk and
// path update, at most one datapath command per cycle.
// ----------------------------------------------------------------------------
module mfb_ctrl
   import mfb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_type,
   output logic       req_ready,
   input  status_type status,
   output op_type     cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = OP_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd = OP_CLEAR;
            if (status.cnt_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_type == REQ_WRITE) begin
                  cmd = OP_WRITE;
               end else begin
                  cmd      = OP_START;
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            state_in = status.run_err ? ST_DONE : ST_COPY_RD;
         end
         ST_COPY_RD: begin
            cmd      = OP_COPY_RD;
            state_in = ST_COPY_WR;
         end
         ST_COPY_WR: begin
            cmd      = OP_COPY_WR;
            state_in = status.cnt_last ? ST_BFS_INIT : ST_COPY_RD;
         end
         ST_BFS_INIT: begin
            cmd      = OP_BFS_INIT;
            state_in = ST_POP;
         end
         ST_POP: begin
            if (status.q_empty) begin
               state_in = ST_DONE;
            end else begin
               cmd      = OP_POP;
               state_in = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            cmd      = OP_SCAN_RD;
            state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            cmd = OP_SCAN_CHK;
            if (status.hit && status.v_snk) begin
               state_in = ST_AUG_INIT;
            end else if (status.v_last) begin
               state_in = ST_POP;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_AUG_INIT: begin
            cmd      = OP_AUG_INIT;
            state_in = ST_MIN_RD;
         end
         ST_MIN_RD: begin
            cmd      = OP_MIN_RD;
            state_in = ST_MIN_CHK;
         end
         ST_MIN_CHK: begin
            cmd      = OP_MIN_CHK;
            state_in = status.u_src ? ST_UPD_INIT : ST_MIN_RD;
         end
         ST_UPD_INIT: begin
            cmd      = OP_UPD_INIT;
            state_in = ST_UPD_RD_F;
         end
         ST_UPD_RD_F: begin
            cmd      = OP_UPD_RD_F;
            state_in = ST_UPD_WR_F;
         end
         ST_UPD_WR_F: begin
            cmd      = OP_UPD_WR_F;
            state_in = ST_UPD_WR_R;
         end
         ST_UPD_WR_R: begin
            cmd      = OP_UPD_WR_R;
            state_in = status.u_src ? ST_BFS_INIT : ST_UPD_RD_F;
         end
         ST_DONE: begin
            if (!status.rsp_busy) begin
               cmd      = OP_FINISH;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/core/mfb_dp.sv
// ----------------------------------------------------------------------------
// mfb_dp
// Datapath: capacity and residual RAMs, search queue, parent links,
// bottleneck and flow accumulator, result register.
// ----------------------------------------------------------------------------
module mfb_dp
   import mfb_pkg::*;
#(
   parameter int MAX_NODES = MAX_NODES_DEF,
   parameter int CAP_BITS  = CAP_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  op_type             cmd,
   input  logic [NODE_W-1:0]  req_row_node,
   input  logic [NODE_W-1:0]  req_col_node,
   input  logic [CAPIN_W-1:0] req_capacity,
   input  logic [NODE_W-1:0]  req_source_node,
   input  logic [NODE_W-1:0]  req_sink_node,
   input  logic               csr_wr_en,
   input  logic [NCNT_W-1:0]  csr_wr_data,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [FLOW_W-1:0]  rsp_total_flow,
   output logic               rsp_error,
   output status_type         status
);

   localparam int IDX_W = $clog2(MAX_NODES);
   localparam int CNT_W = $clog2(MAX_NODES + 1);
   localparam int ADR_W = 2 * IDX_W;
   localparam int DEPTH = 1 << ADR_W;
   localparam int RES_W = CAP_BITS + IDX_W + 1;
   localparam int ACC_W = ((RES_W > FLOW_W) ? RES_W : FLOW_W) + 1;

   logic [NCNT_W-1:0] ncount_ff;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [IDX_W-1:0]  src_ff, snk_ff, u_ff, v_ff;
   logic              err_ff;
   logic [ADR_W-1:0]  cnt_ff;
   logic [CNT_W-1:0]  head_ff, tail_ff;
   logic [MAX_NODES-1:0] vis_ff;
   logic [IDX_W-1:0]  par_ff [MAX_NODES];
   logic [IDX_W-1:0]  queue_ff [MAX_NODES];
   logic [RES_W-1:0]  bn_ff;
   logic [FLOW_W-1:0] flow_ff;
   logic              rsp_valid_ff;
   logic [FLOW_W-1:0] rsp_flow_ff;
   logic              rsp_err_ff;

   logic [7:0]        row8, col8, src8, snk8, n8;
   logic [31:0]       cap32;
   logic [IDX_W-1:0]  par_v;
   logic              cap_we;
   logic [ADR_W-1:0]  cap_waddr;
   logic [CAP_BITS-1:0] cap_wdata, cap_rd;
   logic              res_we;
   logic [ADR_W-1:0]  res_waddr, res_raddr;
   logic [RES_W-1:0]  res_wdata, res_rd;
   logic [ACC_W-1:0]  flow_sum;
   logic              hit;

   assign row8  = 8'(req_row_node);
   assign col8  = 8'(req_col_node);
   assign src8  = 8'(req_source_node);
   assign snk8  = 8'(req_sink_node);
   assign cap32 = 32'(req_capacity);
   assign n8    = 8'(n_ff);
   assign n_in  = (8'(ncount_ff) > 8'(MAX_NODES)) ? CNT_W'(MAX_NODES) : CNT_W'(ncount_ff);
   assign par_v = par_ff[v_ff];
   assign hit   = (res_rd != '0) && !vis_ff[v_ff];
   assign flow_sum = ACC_W'(flow_ff) + ACC_W'(bn_ff);

   // capacity RAM write side
   always_comb begin
      cap_we    = 1'b0;
      cap_waddr = cnt_ff;
      cap_wdata = '0;
      if (cmd == OP_CLEAR) begin
         cap_we = 1'b1;
      end else if (cmd == OP_WRITE) begin
         cap_we    = (row8 < 8'(MAX_NODES)) && (col8 < 8'(MAX_NODES));
         cap_waddr = {row8[IDX_W-1:0], col8[IDX_W-1:0]};
         cap_wdata = cap32[CAP_BITS-1:0];
      end
   end

   // residual RAM ports
   always_comb begin
      res_we    = 1'b0;
      res_waddr = cnt_ff;
      res_wdata = RES_W'(cap_rd);
      res_raddr = {par_v, v_ff};
      case (cmd)
         OP_COPY_WR: res_we = 1'b1;
         OP_SCAN_RD: res_raddr = {u_ff, v_ff};
         OP_UPD_WR_F: begin
            res_we    = 1'b1;
            res_waddr = {par_v, v_ff};
            res_wdata = res_rd - bn_ff;
            res_raddr = {v_ff, par_v};
         end
         OP_UPD_WR_R: begin
            res_we    = 1'b1;
            res_waddr = {v_ff, par_v};
            res_wdata = res_rd + bn_ff;
         end
         default: ;
      endcase
   end

   mfb_ram #(.WIDTH(CAP_BITS), .DEPTH(DEPTH)) u_cap_ram (
      .clock   (clock),
      .wr_en   (cap_we),
      .wr_addr (cap_waddr),
      .wr_data (cap_wdata),
      .rd_addr (cnt_ff),
      .rd_data (cap_rd)
   );

   mfb_ram #(.WIDTH(RES_W), .DEPTH(DEPTH)) u_res_ram (
      .clock   (clock),
      .wr_en   (res_we),
      .wr_addr (res_waddr),
      .wr_data (res_wdata),
      .rd_addr (res_raddr),
      .rd_data (res_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ncount_ff    <= NCOUNT_RST;
         cnt_ff       <= '0;
         vis_ff       <= '0;
         flow_ff      <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) ncount_ff <= csr_wr_data;
         if (cmd == OP_FINISH) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (cmd)
            OP_CLEAR: cnt_ff <= cnt_ff + 1'b1;
            OP_COPY_WR: cnt_ff <= cnt_ff + 1'b1;
            OP_START: begin
               n_ff    <= n_in;
               src_ff  <= src8[IDX_W-1:0];
               snk_ff  <= snk8[IDX_W-1:0];
               err_ff  <= (src8 == snk8) || (src8 >= 8'(n_in)) || (snk8 >= 8'(n_in));
               flow_ff <= '0;
               cnt_ff  <= '0;
            end
            OP_BFS_INIT: begin
               // drop every mark but the source
               vis_ff           <= MAX_NODES'(1) << src_ff;
               queue_ff[0]      <= src_ff;
               head_ff          <= '0;
               tail_ff          <= CNT_W'(1);
            end
            OP_POP: begin
               u_ff    <= queue_ff[head_ff[IDX_W-1:0]];
               head_ff <= head_ff + 1'b1;
               v_ff    <= '0;
            end
            OP_SCAN_CHK: begin
               if (hit) begin
                  par_ff[v_ff] <= u_ff;
                  vis_ff[v_ff] <= 1'b1;
                  if ((v_ff != snk_ff) && (8'(tail_ff) < 8'(MAX_NODES))) begin
                     queue_ff[tail_ff[IDX_W-1:0]] <= v_ff;
                     tail_ff <= tail_ff + 1'b1;
                  end
               end
               v_ff <= v_ff + 1'b1;
            end
            OP_AUG_INIT: begin
               v_ff  <= snk_ff;
               bn_ff <= '1;
            end
            OP_UPD_INIT: begin
               v_ff <= snk_ff;
            end
            OP_MIN_CHK: begin
               if (res_rd < bn_ff) bn_ff <= res_rd;
               v_ff <= par_v;
            end
            OP_UPD_WR_R: begin
               v_ff <= par_v;
               if (par_v == src_ff) begin
                  // saturate the running total
                  flow_ff <= (flow_sum > ACC_W'(FLOW_MAX)) ? FLOW_MAX : flow_sum[FLOW_W-1:0];
               end
            end
            OP_FINISH: begin
               rsp_flow_ff  <= err_ff ? '0 : flow_ff;
               rsp_err_ff   <= err_ff;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      status.run_err  = err_ff;
      status.rsp_busy = rsp_valid_ff && !rsp_ready;
      status.q_empty  = (head_ff == tail_ff);
      status.hit      = hit;
      status.v_snk    = (v_ff == snk_ff);
      status.v_last   = (8'(v_ff) + 8'd1 == n8);
      status.u_src    = (par_v == src_ff);
      status.cnt_last = (cnt_ff == '1);
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_total_flow = rsp_flow_ff;
   assign rsp_error      = rsp_err_ff;

endmodule

// File: rtl/core/max_flow_bfs_augment.sv
// ----------------------------------------------------------------------------
// max_flow_bfs_augment
// Shortest augmenting path maximum flow over a stored capacity matrix.
// ----------------------------------------------------------------------------
// Usage:
//   req_* is a valid/ready input channel. A word with req_type 0 writes one
//   capacity entry and gives no result. A word with req_type 1
//   runs the flow search from req_source_node to req_sink_node and gives one
//   rsp_* word (rsp_total_flow, rsp_error).
//   csr_wr_en/csr_wr_data set node_count; write it only while idle.
// Sequence: a bad run goes from the check straight to posting its result,
//   then the block is ready for the next word. A good run does the check,
//   copies all 2^(2*clog2(MAX_NODES)) matrix entries (256 by default) into
//   the residual RAM, then per search starts, dequeues nodes and scans their
//   entries until the queue runs dry or the sink is found, per path walks the
//   path edges for the bottleneck and then updates each edge, and at the end
//   posts the result. Search and path steps share the single residual RAM read port.
// Reset: a clearing pass over all 2^(2*clog2(MAX_NODES)) entries (256 by
//   default) zeroes the capacity RAM; no word is accepted meanwhile.
// Stall: the result sits in an output register; write words keep being
//   taken while it waits, a finished run holds until the register frees.
// ----------------------------------------------------------------------------
module max_flow_bfs_augment
   import mfb_pkg::*;
#(
   parameter int MAX_NODES = MAX_NODES_DEF,
   parameter int CAP_BITS  = CAP_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_type,
   input  logic [NODE_W-1:0]  req_row_node,
   input  logic [NODE_W-1:0]  req_col_node,
   input  logic [CAPIN_W-1:0] req_capacity,
   input  logic [NODE_W-1:0]  req_source_node,
   input  logic [NODE_W-1:0]  req_sink_node,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [FLOW_W-1:0]  rsp_total_flow,
   output logic               rsp_error,
   input  logic               csr_wr_en,
   input  logic [NCNT_W-1:0]  csr_wr_data
);

   op_type     cmd;
   status_type status;

   mfb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mfb_dp #(.MAX_NODES(MAX_NODES), .CAP_BITS(CAP_BITS)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_row_node    (req_row_node),
      .req_col_node    (req_col_node),
      .req_capacity    (req_capacity),
      .req_source_node (req_source_node),
      .req_sink_node   (req_sink_node),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_total_flow  (rsp_total_flow),
      .rsp_error       (rsp_error),
      .status          (status)
   );

endmodule

// File: test/max_flow_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfb_checker
// Watches the request, response and CSR ports of the max flow block, keeps
// its own capacity matrix and node count, computes the expected flow of
// every accepted run word and compares it with the responses in order.
// ----------------------------------------------------------------------------
module mfb_checker
   import mfb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic               req_type,
   input  logic [NODE_W-1:0]  req_row_node,
   input  logic [NODE_W-1:0]  req_col_node,
   input  logic [CAPIN_W-1:0] req_capacity,
   input  logic [NODE_W-1:0]  req_source_node,
   input  logic [NODE_W-1:0]  req_sink_node,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [FLOW_W-1:0]  rsp_total_flow,
   input  logic               rsp_error,
   input  logic               csr_wr_en,
   input  logic [NCNT_W-1:0]  csr_wr_data,
   output int                 fail_count,
   output int                 flows_pending,
   output int                 write_count,
   output int                 run_count,
   output int                 flagged_count
);

   localparam int NODES = MAX_NODES_DEF;

   typedef struct {
      logic [FLOW_W-1:0] flow;
      logic              err;
   } flow_result_type;

   logic [CAPIN_W-1:0] cap_matrix [NODES][NODES];
   logic [NCNT_W-1:0]  node_count;
   flow_result_type    expected_flows [$];

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      fail_count++;
   endtask

   // shortest augmenting paths on a private residual copy; mark on enqueue
   function automatic flow_result_type compute_flow(input logic [NODE_W-1:0] src,
                                                    input logic [NODE_W-1:0] snk);
      logic [20:0]       resid [NODES][NODES];
      logic [NODE_W-1:0] parent [NODES];
      logic              seen [NODES];
      logic [NODE_W-1:0] frontier [NODES];
      int                head, tail, n, u, v;
      logic              found;
      logic [20:0]       bottleneck;
      logic [23:0]       total;
      flow_result_type   r;
      n = (int'(node_count) > NODES) ? NODES : int'(node_count);
      if (src == snk || src >= n || snk >= n) begin
         r.flow = '0;
         r.err  = 1'b1;
         return r;
      end
      for (int i = 0; i < NODES; i++)
         for (int j = 0; j < NODES; j++)
            resid[i][j] = 21'(cap_matrix[i][j]);
      total = '0;
      forever begin
         found = 1'b0;
         for (int i = 0; i < NODES; i++) seen[i] = 1'b0;
         head = 0;
         tail = 1;
         frontier[0] = src;
         seen[src] = 1'b1;
         while (head < tail && !found) begin
            u = int'(frontier[head]);
            head++;
            for (v = 0; v < n && !found; v++) begin
               if (resid[u][v] != 0 && !seen[v]) begin
                  parent[v] = NODE_W'(u);
                  seen[v] = 1'b1;
                  if (v == snk) found = 1'b1;
                  else if (tail < NODES) begin
                     frontier[tail] = NODE_W'(v);
                     tail++;
                  end
               end
            end
         end
         if (!found) break;
         bottleneck = '1;
         v = int'(snk);
         while (v != src) begin
            u = int'(parent[v]);
            if (resid[u][v] < bottleneck) bottleneck = resid[u][v];
            v = u;
         end
         v = int'(snk);
         while (v != src) begin
            u = int'(parent[v]);
            resid[u][v] -= bottleneck;
            resid[v][u] += bottleneck;
            v = u;
         end
         total = total + 24'(bottleneck);
      end
      r.flow = (total > 24'(FLOW_MAX)) ? FLOW_MAX : total[FLOW_W-1:0];
      r.err  = 1'b0;
      return r;
   endfunction

   always @(posedge clock) begin
      flow_result_type exp_r;
      if (reset) begin
         for (int i = 0; i < NODES; i++)
            for (int j = 0; j < NODES; j++)
               cap_matrix[i][j] = '0;
         node_count = NCOUNT_RST;
         expected_flows.delete();
         fail_count    = 0;
         write_count   = 0;
         run_count     = 0;
         flagged_count = 0;
      end else begin
         if (csr_wr_en) node_count = csr_wr_data;
         if (req_valid && req_ready) begin
            if (req_type == REQ_WRITE) begin
               cap_matrix[req_row_node][req_col_node] = req_capacity;
               write_count++;
            end else begin
               exp_r = compute_flow(req_source_node, req_sink_node);
               expected_flows.push_back(exp_r);
               run_count++;
               if (exp_r.err) flagged_count++;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_flows.size() == 0) begin
               report_mismatch("response word with no run outstanding");
            end else begin
               exp_r = expected_flows.pop_front();
               if (rsp_total_flow !== exp_r.flow)
                  report_mismatch($sformatf("total flow %0d, expected %0d",
                                            rsp_total_flow, exp_r.flow));
               if (rsp_error !== exp_r.err)
                  report_mismatch($sformatf("error %0b, expected %0b",
                                            rsp_error, exp_r.err));
            end
         end
      end
      flows_pending = expected_flows.size();
   end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the max flow block: directed capacity writes and runs, then
// random graphs over a range of node counts with varying back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
   import mfb_pkg::*;

   localparam int STALL_LIMIT = 5000000;
   localparam int QUIET_CYCLES = 20;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_type = 1'b0;
   logic [NODE_W-1:0]  req_row_node = '0;
   logic [NODE_W-1:0]  req_col_node = '0;
   logic [CAPIN_W-1:0] req_capacity = '0;
   logic [NODE_W-1:0]  req_source_node = '0;
   logic [NODE_W-1:0]  req_sink_node = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [FLOW_W-1:0]  rsp_total_flow;
   logic               rsp_error;
   logic               csr_wr_en = 1'b0;
   logic [NCNT_W-1:0]  csr_wr_data = '0;

   int fail_count, flows_pending, write_count, run_count, flagged_count;
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int stall_cycles = 0;

   max_flow_bfs_augment dut (.*);

   mfb_checker u_checker (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // hold the word until taken, then maybe drop valid while a random draw stays under tx_idle_pct
   task automatic send_word(input logic t, input logic [NODE_W-1:0] r,
                            input logic [NODE_W-1:0] c, input logic [CAPIN_W-1:0] cap,
                            input logic [NODE_W-1:0] s, input logic [NODE_W-1:0] k);
      req_valid       <= 1'b1;
      req_type        <= t;
      req_row_node    <= r;
      req_col_node    <= c;
      req_capacity    <= cap;
      req_source_node <= s;
      req_sink_node   <= k;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < tx_idle_pct);
      end
   endtask

   task automatic write_cap(input int r, input int c, input int cap);
      send_word(REQ_WRITE, NODE_W'(r), NODE_W'(c), CAPIN_W'(cap),
                NODE_W'($urandom), NODE_W'($urandom));
   endtask

   task automatic run_flow(input int s, input int k);
      send_word(REQ_RUN, NODE_W'($urandom), NODE_W'($urandom), CAPIN_W'($urandom),
                NODE_W'(s), NODE_W'(k));
   endtask

   // drain all outstanding runs, then let the last write settle
   task automatic wait_quiet();
      req_valid <= 1'b0;
      do @(negedge clock); while (flows_pending != 0);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic set_node_count(input int value);
      wait_quiet();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= NCNT_W'(value);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      @(posedge clock);
   endtask

   function automatic int pick_cap();
      case ($urandom_range(9))
         0: return 0;
         1: return 16'hFFFF;
         2, 3: return $urandom_range(16'hFFFF);
         default: return $urandom_range(1, 50);
      endcase
   endfunction

   task automatic random_phase(input int count, input int nodes);
      int span, done, burst, s, k;
      span = (nodes > MAX_NODES_DEF) ? MAX_NODES_DEF : ((nodes < 2) ? 2 : nodes);
      done = 0;
      while (done < count) begin
         if ($urandom_range(99) < 75) begin
            // well-formed: a few edges among the first span nodes, then a run with distinct source and sink
            burst = $urandom_range(1, 8);
            repeat (burst) begin
               write_cap($urandom_range(span - 1), $urandom_range(span - 1), pick_cap());
            end
            s = $urandom_range(span - 1);
            k = (s + $urandom_range(1, span - 1)) % span;
            run_flow(s, k);
            done += burst + 1;
         end else begin
            if ($urandom_range(1)) write_cap($urandom_range(15), $urandom_range(15),
                                             pick_cap());
            else run_flow($urandom_range(15), $urandom_range(15));
            done++;
         end
      end
   endtask

   initial begin
      int phase_nodes [11] = '{4, 2, 6, 16, 3, 31, 5, 0, 8, 1, 7};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default node count: widest edges at the far corners
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      run_flow(0, 15);
      write_cap(0, 15, 16'hFFFF);
      write_cap(15, 0, 16'hFFFF);
      run_flow(0, 15);
      run_flow(15, 0);
      run_flow(7, 7);
      write_cap(0, 1, 16'h8000);
      write_cap(1, 15, 16'h7FFF);
      write_cap(0, 2, 1);
      write_cap(2, 1, 16'hFFFF);
      run_flow(0, 15);
      write_cap(0, 15, 0);
      run_flow(0, 15);
      set_node_count(2);
      run_flow(0, 15);
      run_flow(1, 0);
      run_flow(0, 1);
      set_node_count(0);
      run_flow(0, 1);
      set_node_count(1);
      run_flow(0, 0);
      set_node_count(31);
      run_flow(0, 15);
      run_flow(15, 1);

      foreach (phase_nodes[p]) begin
         if (p < 4) begin
            tx_idle_pct = 31;
            rx_idle_pct = 76;
         end else if (p < 8) begin
            tx_idle_pct = 76;
            rx_idle_pct = 31;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         set_node_count(phase_nodes[p]);
         random_phase(160, phase_nodes[p]);
      end

      wait_quiet();
      $display("covered %0d capacity writes and %0d max flow runs (%0d flagged)",
               write_count, run_count, flagged_count);
      $display("node counts 0 to 31, sender and receiver stalls in both mixes");
      if (fail_count == 0 && flows_pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
